@@ sv/swrr_pkg.sv @@
// Shared types and constants for the selective-repeat receive window.
// Used by the window cells, the top level and the port checker.
// No dependencies.
package swrr_pkg;

    localparam int WINDOW_DEF       = 8;
    localparam int SEQ_BITS_DEF     = 16;
    localparam int PAYLOAD_BITS_DEF = 32;

    localparam int SEQ_W = 16;
    localparam int PAY_W = 32;

    localparam logic KIND_DATA = 1'b0;
    localparam logic KIND_ACK  = 1'b1;

    typedef enum logic {
        S_IN,
        S_DRAIN
    } t_state;

    typedef struct packed {
        logic wr_en;
        logic shift;
    } t_cell_ctl;

endpackage

@@ sv/swrr_cell.sv @@
// One slot of the receive window: a valid bit and a stored payload.
// Loads an arriving payload or takes its upper neighbor's contents on a shift.
// Depends on swrr_pkg.
module swrr_cell #(
    parameter int PAYLOAD_BITS = swrr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  swrr_pkg::t_cell_ctl     i_ctl,
    input  logic [PAYLOAD_BITS-1:0] i_wr_payload,
    input  logic                    i_nb_valid,
    input  logic [PAYLOAD_BITS-1:0] i_nb_payload,
    output logic                    o_valid,
    output logic [PAYLOAD_BITS-1:0] o_payload
);

    logic                    r_valid;
    logic                    n_valid;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [PAYLOAD_BITS-1:0] n_payload;

    always_comb begin
        n_valid   = r_valid;
        n_payload = r_payload;
        if (i_ctl.shift) begin
            n_valid   = i_nb_valid;
            n_payload = i_nb_payload;
        end else if (i_ctl.wr_en) begin
            n_valid   = 1'b1;
            n_payload = i_wr_payload;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_payload <= n_payload;
    end

    assign o_valid   = r_valid;
    assign o_payload = r_payload;

endmodule

@@ sv/sliding_window_reorder_receiver.sv @@
// Selective-repeat receive window: slot cells, window head counter and result register.
// Depends on swrr_pkg and swrr_cell.
//
// Input channel (i_in_valid / o_in_ready) takes one packet item: sequence number
// and payload word. A number within WINDOW of the expected number is stored in
// its slot, overwriting any earlier copy; anything else is dropped.
// Output channel (o_out_valid / i_out_ready) gives result items: first every
// stored packet at the head of the window in order (kind 0), then one cumulative
// acknowledgement of expected minus one (kind 1, last set, payload zero).
// Timing: the item is stored in the cycle it is accepted; the block then drains,
// delivering each stored packet as the slot chain shifts down by one, and then the
// acknowledgement. No new item is taken until the acknowledgement is loaded.
// Each result is loaded into the output register from the drain state. A single
// output register parts the channels: the next item is taken while the
// acknowledgement waits.
// When the receiver stalls, the drain holds and the slot chain does not shift.
// Reset clears all slot valid bits, the expected number and the output valid bit.
module sliding_window_reorder_receiver #(
    parameter int WINDOW       = swrr_pkg::WINDOW_DEF,
    parameter int SEQ_BITS     = swrr_pkg::SEQ_BITS_DEF,
    parameter int PAYLOAD_BITS = swrr_pkg::PAYLOAD_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [swrr_pkg::SEQ_W-1:0] i_seq_num,
    input  logic [swrr_pkg::PAY_W-1:0] i_payload_word,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_kind,
    output logic [swrr_pkg::SEQ_W-1:0] o_out_seq,
    output logic [swrr_pkg::PAY_W-1:0] o_out_payload,
    output logic                       o_last
);

    swrr_pkg::t_state r_state;
    swrr_pkg::t_state n_state;

    logic [SEQ_BITS-1:0]     r_expected;
    logic [SEQ_BITS-1:0]     n_expected;
    logic [SEQ_BITS-1:0]     w_seq;
    logic [SEQ_BITS-1:0]     w_offset;
    logic [SEQ_BITS-1:0]     w_ack_seq;
    logic [PAYLOAD_BITS-1:0] w_in_payload;
    logic                    w_accept;
    logic                    w_in_win;
    logic                    w_out_free;
    logic                    w_shift;
    logic                    w_load_data;
    logic                    w_load_ack;

    logic                    w_valid   [WINDOW];
    logic [PAYLOAD_BITS-1:0] w_payload [WINDOW];

    logic                       r_out_valid;
    logic                       n_out_valid;
    logic                       r_kind;
    logic                       n_kind;
    logic [swrr_pkg::SEQ_W-1:0] r_out_seq;
    logic [swrr_pkg::SEQ_W-1:0] n_out_seq;
    logic [swrr_pkg::PAY_W-1:0] r_out_payload;
    logic [swrr_pkg::PAY_W-1:0] n_out_payload;
    logic                       r_last;
    logic                       n_last;

    assign w_accept     = i_in_valid && o_in_ready;
    assign w_seq        = SEQ_BITS'(i_seq_num);
    assign w_in_payload = PAYLOAD_BITS'(i_payload_word);
    assign w_offset     = w_seq - r_expected;
    assign w_in_win     = (32'(w_offset) < 32'(WINDOW));
    assign w_ack_seq    = r_expected - SEQ_BITS'(1);
    assign w_out_free   = !r_out_valid || i_out_ready;

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        swrr_pkg::t_cell_ctl     w_ctl;
        logic                    w_nb_valid;
        logic [PAYLOAD_BITS-1:0] w_nb_payload;

        assign w_ctl.wr_en = w_accept && w_in_win && (32'(w_offset) == 32'(g));
        assign w_ctl.shift = w_shift;

        if (g == WINDOW - 1) begin : g_top
            assign w_nb_valid   = 1'b0;
            assign w_nb_payload = '0;
        end else begin : g_mid
            assign w_nb_valid   = w_valid[g+1];
            assign w_nb_payload = w_payload[g+1];
        end

        swrr_cell #(
            .PAYLOAD_BITS(PAYLOAD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_wr_payload(w_in_payload),
            .i_nb_valid  (w_nb_valid),
            .i_nb_payload(w_nb_payload),
            .o_valid     (w_valid[g]),
            .o_payload   (w_payload[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swrr_pkg::S_IN: begin
                if (w_accept) begin
                    n_state = swrr_pkg::S_DRAIN;
                end
            end
            swrr_pkg::S_DRAIN: begin
                if (!w_valid[0] && w_out_free) begin
                    n_state = swrr_pkg::S_IN;
                end
            end
            default: begin
                n_state = swrr_pkg::S_IN;
            end
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        w_load_data = 1'b0;
        w_load_ack  = 1'b0;
        case (r_state)
            swrr_pkg::S_IN: begin
                o_in_ready = 1'b1;
            end
            swrr_pkg::S_DRAIN: begin
                w_load_data = w_valid[0] && w_out_free;
                w_load_ack  = !w_valid[0] && w_out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_shift    = w_load_data;
    assign n_expected = w_load_data ? (r_expected + SEQ_BITS'(1)) : r_expected;

    always_comb begin
        n_out_valid   = r_out_valid;
        n_kind        = r_kind;
        n_out_seq     = r_out_seq;
        n_out_payload = r_out_payload;
        n_last        = r_last;
        if (w_load_data) begin
            n_out_valid   = 1'b1;
            n_kind        = swrr_pkg::KIND_DATA;
            n_out_seq     = swrr_pkg::SEQ_W'(r_expected);
            n_out_payload = swrr_pkg::PAY_W'(w_payload[0]);
            n_last        = 1'b0;
        end else if (w_load_ack) begin
            n_out_valid   = 1'b1;
            n_kind        = swrr_pkg::KIND_ACK;
            n_out_seq     = swrr_pkg::SEQ_W'(w_ack_seq);
            n_out_payload = '0;
            n_last        = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= swrr_pkg::S_IN;
            r_expected  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_expected  <= n_expected;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind        <= n_kind;
        r_out_seq     <= n_out_seq;
        r_out_payload <= n_out_payload;
        r_last        <= n_last;
    end

    assign o_out_valid   = r_out_valid;
    assign o_kind        = r_kind;
    assign o_out_seq     = r_out_seq;
    assign o_out_payload = r_out_payload;
    assign o_last        = r_last;

endmodule

@@ sv/swrr_checker.sv @@
// Port-level checks for the selective-repeat receive window.
// Bound to sliding_window_reorder_receiver; depends on swrr_pkg.
module swrr_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_kind,
    input logic [swrr_pkg::SEQ_W-1:0] o_out_seq,
    input logic [swrr_pkg::PAY_W-1:0] o_out_payload,
    input logic                       o_last
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_kind)
            && $stable(o_out_seq) && $stable(o_out_payload) && $stable(o_last))
        else $error("stalled output item changed");

    a_last_is_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind == swrr_pkg::KIND_ACK)))
        else $error("last flag does not match acknowledgement kind");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == swrr_pkg::KIND_ACK |-> o_out_payload == '0)
        else $error("acknowledgement carries a payload");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second item taken before acknowledgement");

endmodule

bind sliding_window_reorder_receiver swrr_checker u_swrr_checker (.*);
